### sv/dps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared constants, sine table and control structs for the DFT power block.
// ----------------------------------------------------------------------------
package dps_pkg;

    // default frame geometry
    localparam int NUM_SAMPLES_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int IN_W      = 16;
    localparam int BIN_W     = 6;
    localparam int POWER_W   = 52;
    localparam int TDATA_W   = 64;
    localparam int SIN_W     = 16;
    localparam int Q_DROP    = 14;
    localparam int TABLE_LEN = 64;
    localparam int TIDX_W    = 6;
    localparam int QUARTER   = TABLE_LEN / 4;
    localparam int DIV_STEPS = POWER_W;
    localparam int SQ_STEPS  = 6;

    // register map
    localparam logic REG_NORM_MODE = 1'b0;

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

    // first quarter of sin() in Q1.15, 1.0 held as 32767
    localparam logic [14:0] QUARTER_WAVE [QUARTER+1] = '{
        15'd0, 15'd3212, 15'd6393, 15'd9512, 15'd12540, 15'd15447, 15'd18205,
        15'd20788, 15'd23170, 15'd25330, 15'd27245, 15'd28899, 15'd30274,
        15'd31357, 15'd32138, 15'd32610, 15'd32767
    };

    // sin(2*pi*i/64) in Q1.15, built from the quarter wave
    function automatic logic signed [SIN_W-1:0] sine_q15(input logic [TIDX_W-1:0] i);
        logic [4:0]  ri;
        logic [15:0] v;
        ri = i[4] ? (5'(QUARTER) - {1'b0, i[3:0]}) : {1'b0, i[3:0]};
        v  = {1'b0, QUARTER_WAVE[ri]};
        return i[5] ? $signed(-v) : $signed(v);
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic load_sample;
        logic frame_end;
        logic frame_done;
        logic bin_start;
        logic next_bin;
        logic mac_issue;
        logic sq_issue;
        logic div_init;
        logic div_step;
        logic load_out;
        logic bin_zero;
        logic bin_last;
    } dps_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mac_busy;
        logic out_full;
    } dps_status_t;

endpackage

### sv/dft_power_spectrum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_power_spectrum_top
// DFT power spectrum of an N-sample count histogram, standard or Leahy norm.
// ----------------------------------------------------------------------------
// Samples load one per cycle while s_tready is high; the last sample of a frame
// starts the spectrum. Each bin runs start, one MAC issue per sample, drain,
// squaring, divider init, restoring divider steps and emit, in that order, on the
// single MAC and divider; emit waits while the previous result is not taken.
// A frame gives N/2+1 results; no sample is taken while the spectrum is computed.
// rst_n is asynchronous: it clears control state and norm_mode; no memory pass.
module dft_power_spectrum_top
    import dps_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // sample stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [15:0] sample
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [5:0] bin_index, [57:6] power, [63:58] zero
    output logic               m_tuser,   // [0] zero_total
    output logic               m_tlast,   // last_bin
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(NUM_SAMPLES);
    localparam int KW = $clog2(NUM_SAMPLES/2+1);

    dps_cmd_t          cmd;
    dps_status_t       status;
    logic [AW-1:0]     wr_addr, mac_addr;
    logic [2:0]        sq_step;
    logic [KW-1:0]     bin;
    logic              norm_mode_reg;
    logic [BIN_W-1:0]  bin_index;
    logic [POWER_W-1:0] power;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NORM_MODE) ? {31'b0, norm_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_NORM_MODE))
        begin
            norm_mode_reg <= pwdata[0];
        end
    end

    dps_ctrl #(.NUM_SAMPLES(NUM_SAMPLES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .mac_addr (mac_addr),
        .sq_step  (sq_step),
        .bin      (bin)
    );

    dps_datapath #(.NUM_SAMPLES(NUM_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .wr_addr    (wr_addr),
        .mac_addr   (mac_addr),
        .sq_step    (sq_step),
        .bin        (bin),
        .norm_mode  (norm_mode_reg),
        .sample     (s_tdata),
        .bin_index  (bin_index),
        .power      (power),
        .zero_total (m_tuser),
        .last_bin   (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    // result packing
    assign m_tdata = {{(TDATA_W - BIN_W - POWER_W){1'b0}}, power, bin_index};

endmodule

### sv/dps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/dps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: sample loading, per-bin MAC pass, squaring, division, emit.
// ----------------------------------------------------------------------------
module dps_ctrl
    import dps_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  dps_status_t                          status,
    output dps_cmd_t                             cmd,
    output logic [$clog2(NUM_SAMPLES)-1:0]       wr_addr,
    output logic [$clog2(NUM_SAMPLES)-1:0]       mac_addr,
    output logic [2:0]                           sq_step,
    output logic [$clog2(NUM_SAMPLES/2+1)-1:0]   bin
);

    localparam int AW   = $clog2(NUM_SAMPLES);
    localparam int KW   = $clog2(NUM_SAMPLES/2+1);
    localparam int CW   = (AW > 6) ? AW : 6;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SAMPLES-1);
    localparam logic [KW-1:0] HALF      = KW'(NUM_SAMPLES/2);
    localparam logic [CW-1:0] MAC_END   = CW'(NUM_SAMPLES-1);
    localparam logic [CW-1:0] SQ_END    = CW'(SQ_STEPS);
    localparam logic [CW-1:0] DIV_END   = CW'(DIV_STEPS-1);

    typedef enum logic [2:0] {
        ST_LOAD, ST_BSTART, ST_MAC, ST_DRAIN, ST_SQUARE, ST_DIVINIT, ST_DIVIDE, ST_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] samp_reg, samp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] bin_reg, bin_next;

    assign wr_addr  = samp_reg;
    assign mac_addr = cnt_reg[AW-1:0];
    assign sq_step  = cnt_reg[2:0];
    assign bin      = bin_reg;
    assign s_tready = (state_reg == ST_LOAD);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        samp_next  = samp_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        cmd        = '0;
        cmd.bin_zero = (bin_reg == '0);
        cmd.bin_last = (bin_reg == HALF);
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    cmd.load_sample = 1'b1;
                    if (samp_reg == LAST_ADDR)
                    begin
                        cmd.frame_end = 1'b1;
                        samp_next     = '0;
                        bin_next      = '0;
                        state_next    = ST_BSTART;
                    end
                    else
                    begin
                        samp_next = samp_reg + 1'b1;
                    end
                end
            end
            ST_BSTART:
            begin
                cmd.bin_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (cnt_reg == MAC_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.mac_busy)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                // last cycle only lets the final partial product land
                if (cnt_reg == SQ_END)
                begin
                    state_next = ST_DIVINIT;
                end
                else
                begin
                    cmd.sq_issue = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_END)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    if (bin_reg == HALF)
                    begin
                        cmd.frame_done = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        cmd.next_bin = 1'b1;
                        bin_next     = bin_reg + 1'b1;
                        state_next   = ST_BSTART;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            samp_reg  <= '0;
            cnt_reg   <= '0;
            bin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            samp_reg  <= samp_next;
            cnt_reg   <= cnt_next;
            bin_reg   <= bin_next;
        end
    end

endmodule

### sv/dps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_datapath
// Sample store, MAC pipeline, split squarer, restoring divider, result reg.
// ----------------------------------------------------------------------------
module dps_datapath
    import dps_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dps_cmd_t                           cmd,
    output dps_status_t                        status,
    input  logic [$clog2(NUM_SAMPLES)-1:0]     wr_addr,
    input  logic [$clog2(NUM_SAMPLES)-1:0]     mac_addr,
    input  logic [2:0]                         sq_step,
    input  logic [$clog2(NUM_SAMPLES/2+1)-1:0] bin,
    input  logic                               norm_mode,
    input  logic [IN_W-1:0]                    sample,
    output logic [BIN_W-1:0]                   bin_index,
    output logic [POWER_W-1:0]                 power,
    output logic                               zero_total,
    output logic                               last_bin,
    output logic                               out_valid,
    input  logic                               out_ready
);

    localparam int SW    = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int AW    = $clog2(NUM_SAMPLES);
    localparam int KW    = $clog2(NUM_SAMPLES/2+1);
    localparam int PW    = SW + 1 + SIN_W;
    localparam int ACC_W = SW + SIN_W + AW;
    localparam int H     = (ACC_W + 1) / 2;
    localparam int SQ_W  = 2 * ACC_W + 2;
    localparam int MPR_W = SQ_W - Q_DROP;
    localparam int MP_W  = (MPR_W > POWER_W) ? MPR_W : POWER_W + 1;
    localparam int TW    = SW + $clog2(NUM_SAMPLES + 1);
    localparam int NN_W  = 2 * AW + 1;
    localparam int DW    = (TW > NN_W) ? TW : NN_W;
    localparam logic [TIDX_W-1:0] A_STEP = TIDX_W'((TABLE_LEN / NUM_SAMPLES) % TABLE_LEN);
    localparam logic [AW:0]       B_STEP = (AW+1)'(TABLE_LEN % NUM_SAMPLES);
    localparam logic [AW:0]       N_W    = (AW+1)'(NUM_SAMPLES);
    localparam logic [DW-1:0]     NN     = DW'(NUM_SAMPLES * NUM_SAMPLES);
    localparam logic [TIDX_W-1:0] COS_OFS = TIDX_W'(QUARTER);

    // frame state
    logic                 mode_reg;
    logic [TW-1:0]        total_reg;
    logic [SW-1:0]        x;
    logic [SW-1:0]        rd_data;

    assign x = SW'(sample);

    dps_ram #(.WIDTH(SW), .DEPTH(NUM_SAMPLES)) u_store (
        .clk   (clk),
        .we    (cmd.load_sample),
        .waddr (wr_addr),
        .wdata (x),
        .raddr (mac_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.frame_end)
            begin
                mode_reg <= norm_mode;
            end
            if (cmd.frame_done)
            begin
                total_reg <= '0;
            end
            else if (cmd.load_sample)
            begin
                total_reg <= total_reg + TW'(x);
            end
        end
    end

    // table phase: idx + r/N tracks (k*j mod N)*64/N, per-bin step a_k + b_k/N
    logic [TIDX_W-1:0] ak_reg, idx_reg;
    logic [AW-1:0]     bk_reg, r_reg;
    logic [AW:0]       bsum, rsum;

    assign bsum = {1'b0, bk_reg} + B_STEP;
    assign rsum = {1'b0, r_reg} + {1'b0, bk_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.frame_end)
        begin
            ak_reg <= '0;
            bk_reg <= '0;
        end
        else if (cmd.next_bin)
        begin
            if (bsum >= N_W)
            begin
                bk_reg <= AW'(bsum - N_W);
                ak_reg <= ak_reg + A_STEP + 1'b1;
            end
            else
            begin
                bk_reg <= AW'(bsum);
                ak_reg <= ak_reg + A_STEP;
            end
        end
        if (cmd.bin_start)
        begin
            idx_reg <= '0;
            r_reg   <= '0;
        end
        else if (cmd.mac_issue)
        begin
            if (rsum >= N_W)
            begin
                r_reg   <= AW'(rsum - N_W);
                idx_reg <= idx_reg + ak_reg + 1'b1;
            end
            else
            begin
                r_reg   <= AW'(rsum);
                idx_reg <= idx_reg + ak_reg;
            end
        end
    end

    // MAC pipeline: read/index, multiply, accumulate
    logic                     v1_reg, v2_reg;
    logic [TIDX_W-1:0]        cidx_reg, sidx_reg;
    logic signed [PW-1:0]     pre_reg, pim_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [SW:0]       xs;

    assign xs = $signed({1'b0, rd_data});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cidx_reg <= idx_reg + COS_OFS;
        sidx_reg <= idx_reg;
        pre_reg  <= xs * sine_q15(cidx_reg);
        pim_reg  <= xs * sine_q15(sidx_reg);
        if (cmd.bin_start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(pre_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(pim_reg);
        end
    end

    assign status.mac_busy = v1_reg | v2_reg;

    // squarer: |X|^2 from half-width partial products, one per cycle
    logic [ACC_W-1:0] mag_re, mag_im, mag_sel;
    logic [H-1:0]     op_a, op_b;
    logic [2*H-1:0]   prod_reg;
    logic [1:0]       part_reg;
    logic             pv_reg;
    logic [1:0]       part;
    logic [SQ_W-1:0]  sq_reg;
    logic [SQ_W-1:0]  term;

    assign mag_re = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign mag_im = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);

    // steps 0..2 real part, 3..5 imaginary: low*low, high*low, high*high
    always_comb
    begin
        case (sq_step)
            3'd0:    begin part = 2'd0; mag_sel = mag_re; end
            3'd1:    begin part = 2'd1; mag_sel = mag_re; end
            3'd2:    begin part = 2'd2; mag_sel = mag_re; end
            3'd3:    begin part = 2'd0; mag_sel = mag_im; end
            3'd4:    begin part = 2'd1; mag_sel = mag_im; end
            3'd5:    begin part = 2'd2; mag_sel = mag_im; end
            default: begin part = 2'd0; mag_sel = '0;     end
        endcase
        op_a = (part == 2'd0) ? mag_sel[H-1:0] : H'(mag_sel >> H);
        op_b = (part == 2'd2) ? H'(mag_sel >> H) : mag_sel[H-1:0];
        case (part_reg)
            2'd1:    term = SQ_W'(prod_reg) << (H + 1);
            2'd2:    term = SQ_W'(prod_reg) << (2 * H);
            default: term = SQ_W'(prod_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.sq_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        part_reg <= part;
        if (cmd.bin_start)
        begin
            sq_reg <= '0;
        end
        else if (pv_reg)
        begin
            sq_reg <= sq_reg + term;
        end
    end

    // divider: 52 restoring steps, saturation decided up front
    logic             dbl;
    logic [SQ_W-1:0]  m_full;
    logic [MP_W-1:0]  mp;
    logic [DW-1:0]    den;
    logic [DW-1:0]    rem_reg;
    logic [DW:0]      trial;
    logic [POWER_W-1:0] dl_reg, q_reg;
    logic             sat_reg;
    logic             zt;

    assign dbl    = mode_reg ? !cmd.bin_last : (!cmd.bin_zero && !cmd.bin_last);
    assign m_full = dbl ? (sq_reg << 1) : sq_reg;
    assign mp     = MP_W'(m_full >> Q_DROP);
    assign den    = mode_reg ? DW'(total_reg) : NN;
    assign trial  = {rem_reg, dl_reg[POWER_W-1]};
    assign zt     = mode_reg && (total_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            sat_reg <= (DW'(mp[MP_W-1:POWER_W]) >= den);
            rem_reg <= DW'(mp[MP_W-1:POWER_W]);
            dl_reg  <= mp[POWER_W-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            dl_reg <= dl_reg << 1;
            if (trial >= {1'b0, den})
            begin
                rem_reg <= DW'(trial - {1'b0, den});
                q_reg   <= {q_reg[POWER_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= DW'(trial);
                q_reg   <= {q_reg[POWER_W-2:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            bin_index  <= BIN_W'(bin);
            power      <= zt ? '0 : (sat_reg ? POWER_MAX : q_reg);
            zero_total <= zt;
            last_bin   <= cmd.bin_last;
        end
    end

    assign status.out_full = out_valid && !out_ready;

endmodule

### sv/dps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks on the result stream and the configuration readback.
// ----------------------------------------------------------------------------
module dps_assert
    import dps_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser,
    input logic               m_tlast,
    input logic [31:0]        prdata
);

    localparam logic [BIN_W-1:0] HALF_BIN = BIN_W'(NUM_SAMPLES / 2);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // zero total forces zero power
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[BIN_W+POWER_W-1:BIN_W] == '0)
        else $error("zero_total with nonzero power");

    // last result of a frame is the Nyquist bin
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[BIN_W-1:0] == HALF_BIN)
        else $error("last_bin on wrong bin");

    // a delivered bin other than the Nyquist bin is not directly followed by bin 0
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || m_tdata[BIN_W-1:0] != '0)
        else $error("bin 0 restarted mid-frame");

    // only the mode bit reads back
    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:1] == '0)
        else $error("reserved readback bits set");

endmodule

bind dft_power_spectrum_top dps_assert #(.NUM_SAMPLES(NUM_SAMPLES)) u_dps_assert (.*);

### tb/sv/dps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_checker
// Watches the sample, result and register channels of the DFT power block.
// Builds the expected spectrum of each finished frame and compares every
// returned bin with it, field by field, in order.
// ----------------------------------------------------------------------------
module dps_checker
    import dps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [15:0] sample
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // [5:0] bin_index, [57:6] power, [63:58] zero
    input  logic               m_tuser,   // [0] zero_total
    input  logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending,
    output int                 bins_seen
);

    localparam int FRAME_LEN = NUM_SAMPLES_DEF;
    localparam int HALF      = FRAME_LEN / 2;
    localparam logic [2:0] ADDR_NORM_MODE = 3'({REG_NORM_MODE, 2'b00});

    typedef struct {
        logic [BIN_W-1:0]   bin;
        logic [POWER_W-1:0] power;
        logic               zero_total;
        logic               last;
    } spectrum_bin_t;

    spectrum_bin_t     spectrum_q[$];
    logic [IN_W-1:0]   frame_samples [FRAME_LEN];
    int                fill_count;
    logic [21:0]       frame_total;
    logic              leahy_mode;
    int                sine_lut [TABLE_LEN];

    assign pending = spectrum_q.size();

    // Q1.15 sine, mirrored and negated from the quarter wave
    initial
    begin
        int quad;
        int r;
        int v;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            quad = i / 16;
            r    = i % 16;
            v    = (quad % 2 == 1) ? int'(QUARTER_WAVE[16 - r]) : int'(QUARTER_WAVE[r]);
            sine_lut[i] = (quad >= 2) ? -v : v;
        end
    end

    // direct DFT of the stored frame, one expected entry per bin 0..N/2
    task automatic compute_spectrum();
        longint         re;
        longint         im;
        longint         ar;
        longint         ai;
        int             idx;
        logic [127:0]   mag2;
        logic [127:0]   den;
        logic [127:0]   quot;
        logic           twice;
        spectrum_bin_t  e;
        for (int k = 0; k <= HALF; k++)
        begin
            re = 0;
            im = 0;
            for (int j = 0; j < FRAME_LEN; j++)
            begin
                idx = ((k * j) % FRAME_LEN) * TABLE_LEN / FRAME_LEN;
                re += longint'(frame_samples[j]) * sine_lut[(idx + 16) % TABLE_LEN];
                im += longint'(frame_samples[j]) * sine_lut[idx % TABLE_LEN];
            end
            ar   = (re < 0) ? -re : re;
            ai   = (im < 0) ? -im : im;
            mag2 = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
            if (leahy_mode)
            begin
                twice = (k != HALF);
                den   = 128'(frame_total) << Q_DROP;
            end
            else
            begin
                twice = (k != 0 && k != HALF);
                den   = 128'(FRAME_LEN * FRAME_LEN) << Q_DROP;
            end
            if (twice)
                mag2 = mag2 << 1;
            e.bin        = BIN_W'(k);
            e.last       = (k == HALF);
            e.zero_total = leahy_mode && (frame_total == 0);
            if (e.zero_total)
                e.power = '0;
            else
            begin
                quot    = mag2 / den;
                e.power = (quot > 128'(POWER_MAX)) ? POWER_MAX : quot[POWER_W-1:0];
            end
            spectrum_q.push_back(e);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        spectrum_bin_t e;
        if (!rst_n)
        begin
            fill_count  <= 0;
            frame_total <= '0;
            leahy_mode  <= 1'b0;
            fail_count  <= 0;
            bins_seen   <= 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready && paddr == ADDR_NORM_MODE)
                leahy_mode <= pwdata[0];

            // sample request
            if (s_tvalid && s_tready)
            begin
                frame_samples[fill_count] = s_tdata;
                frame_total = frame_total + s_tdata;
                if (fill_count == FRAME_LEN - 1)
                begin
                    compute_spectrum();
                    fill_count  <= 0;
                    frame_total = '0;
                end
                else
                    fill_count <= fill_count + 1;
            end

            // result request
            if (m_tvalid && m_tready)
            begin
                bins_seen <= bins_seen + 1;
                if (spectrum_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result bin=%0d power=%0d",
                                 m_tdata[5:0], m_tdata[57:6]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = spectrum_q.pop_front();
                    if (m_tdata[5:0] !== e.bin || m_tdata[57:6] !== e.power
                        || m_tdata[63:58] !== 6'd0 || m_tuser !== e.zero_total
                        || m_tlast !== e.last)
                    begin
                        if (fail_count < 10)
                            $display({"ERROR: bin mismatch exp bin=%0d pw=%0d zt=%0b last=%0b",
                                      " got bin=%0d pw=%0d pad=%0h zt=%0b last=%0b"},
                                     e.bin, e.power, e.zero_total, e.last,
                                     m_tdata[5:0], m_tdata[57:6], m_tdata[63:58],
                                     m_tuser, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level test of the DFT power spectrum block.
// Streams full sample frames under both normalizations, with random gaps and
// output backpressure on all but the last; the checker predicts and compares every bin.
// ----------------------------------------------------------------------------
module tb;
    import dps_pkg::*;

    localparam int FRAME_LEN = NUM_SAMPLES_DEF;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 bins_seen;
    logic               gaps_on;
    int                 stall_left;
    int                 frames_sent;
    logic [IN_W-1:0]    frame_buf [FRAME_LEN];

    dft_power_spectrum_top dut (.*);

    dps_checker chk (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .fail_count, .pending, .bins_seen
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic reg_write(input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = 3'({REG_NORM_MODE, 2'b00});
        pwdata  = value;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // hold off until the spectrum is out and the block has settled
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic push_sample(input logic [IN_W-1:0] x);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = x;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_frame(input logic mode);
        wait_quiet();
        reg_write({31'd0, mode});
        for (int i = 0; i < FRAME_LEN; i++)
            push_sample(frame_buf[i]);
        frames_sent++;
    endtask

    // kind 0 full range, 1 low counts, 2 sparse spikes
    task automatic fill_random(input int kind);
        for (int i = 0; i < FRAME_LEN; i++)
            case (kind)
                0:       frame_buf[i] = IN_W'($urandom);
                1:       frame_buf[i] = IN_W'($urandom_range(0, 15));
                default: frame_buf[i] = ($urandom_range(0, 9) == 0) ? IN_W'($urandom) : '0;
            endcase
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gaps_on     = 1'b1;
        stall_left  = 0;
        frames_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full-scale frame, standard norm
        foreach (frame_buf[i]) frame_buf[i] = '1;
        send_frame(1'b0);
        // empty frame, Leahy: zero-total flag on every bin
        foreach (frame_buf[i]) frame_buf[i] = '0;
        send_frame(1'b1);
        // sparse spikes, Leahy
        fill_random(2);
        send_frame(1'b1);

        // final random frame with no gaps
        gaps_on = 1'b0;
        fill_random(0);
        send_frame(1'b0);

        wait_quiet();
        $display("Covered %0d frames (%0d samples) and %0d spectrum bins,",
                 frames_sent, frames_sent * FRAME_LEN, bins_seen);
        $display("standard and Leahy norms, zero total, spikes, full-scale and random counts.");
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
sv/dps_pkg.sv
sv/dps_ram.sv
sv/dps_ctrl.sv
sv/dps_datapath.sv
sv/dft_power_spectrum_top.sv
sv/dps_checker.sv
tb/sv/dps_checker.sv
tb/sv/tb.sv
